FILE: sv/h2r_pkg.sv
// package with the types and constants of the hsv to rgb converter
package h2r_pkg;

    // percent, degree and channel limits
    localparam logic [6:0]  C_PCT_MAX        = 7'd100;
    localparam logic [5:0]  C_DEG_PER_SECTOR = 6'd60;
    localparam logic [8:0]  C_HUE_LIMIT      = 9'd360;

    // common weight: every channel is 255*v*x/600000 with x in 0..6000
    localparam int          C_WEIGHT_W       = 13;
    localparam logic [12:0] C_WEIGHT_FULL    = 13'd6000;

    // reciprocal of 600000, exact floor for products below 2^28
    localparam int          C_PROD_W         = 28;
    localparam int          C_RECIP_SHIFT    = 47;
    localparam logic [27:0] C_RECIP          = 28'd234562481;

    // hue sectors of sixty degrees each
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    typedef logic [C_WEIGHT_W-1:0] t_weight;

    // first hue degree of a sector
    function automatic logic [8:0] sector_base(input t_sector sec);
        logic [8:0] base;
        case (sec)
            SEC_R_TO_Y: base = 9'd0;
            SEC_Y_TO_G: base = 9'd60;
            SEC_G_TO_C: base = 9'd120;
            SEC_C_TO_B: base = 9'd180;
            SEC_B_TO_M: base = 9'd240;
            SEC_M_TO_R: base = 9'd300;
            default:    base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

FILE: sv/hsv_to_rgb_converter.sv
// hsv to rgb converter: four stage pipeline from hsv percent input to 8-bit rgb
//
// input channel: i_valid with i_hue_degrees, i_saturation_pct and i_value_pct;
// a transfer happens at a clock edge with i_valid high and o_stall low.
// output channel: o_valid with o_red, o_green and o_blue; a transfer happens
// at a clock edge with o_valid high and i_stall low.
// every input transfer yields exactly one output transfer, in order.
// after its input transfer, a result passes through the stage registers r1 to r4
// to the outputs. throughput: one item per cycle while i_stall holds no result;
// the work is split over four register stages (sector split, weight select,
// 15x13 weight multiply, 28x28 reciprocal multiply that divides by 600000).
// saturation and value above 100 are clipped to 100. a hue of 360 or more
// gives black unless saturation is zero, which gives grey.
// when the receiver holds i_stall while a result waits, the whole pipeline
// freezes and o_stall goes high; no item is lost or repeated.
// reset (i_rst_n low, synchronous) clears all valid bits and empties the
// pipeline; the first item can be taken in the cycle after reset drops.
module hsv_to_rgb_converter
    import h2r_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [8:0] i_hue_degrees,
    input  logic [6:0] i_saturation_pct,
    input  logic [6:0] i_value_pct,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    // pipeline advance: hold everything only when the output is full and stalled
    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // stage 1: clip percentages, find sector and fraction, flag black, scale value by 255
    logic [6:0]  n1_sat, n1_val;
    t_sector     n1_sec;
    logic [5:0]  n1_frac;
    logic [8:0]  n1_frac_full;
    logic        n1_black;
    logic [14:0] n1_v255;

    always_comb begin
        n1_sat = (i_saturation_pct > C_PCT_MAX) ? C_PCT_MAX : i_saturation_pct;
        n1_val = (i_value_pct > C_PCT_MAX) ? C_PCT_MAX : i_value_pct;
        if (i_hue_degrees >= 9'd300) begin
            n1_sec = SEC_M_TO_R;
        end else if (i_hue_degrees >= 9'd240) begin
            n1_sec = SEC_B_TO_M;
        end else if (i_hue_degrees >= 9'd180) begin
            n1_sec = SEC_C_TO_B;
        end else if (i_hue_degrees >= 9'd120) begin
            n1_sec = SEC_G_TO_C;
        end else if (i_hue_degrees >= 9'd60) begin
            n1_sec = SEC_Y_TO_G;
        end else begin
            n1_sec = SEC_R_TO_Y;
        end
        n1_frac_full = i_hue_degrees - sector_base(n1_sec);
        n1_frac      = n1_frac_full[5:0];
        n1_black     = (i_hue_degrees >= C_HUE_LIMIT) && (n1_sat != 7'd0);
        n1_v255      = {n1_val, 8'd0} - {8'd0, n1_val};
    end

    logic        r1_valid;
    logic [6:0]  r1_sat;
    t_sector     r1_sec;
    logic [5:0]  r1_frac;
    logic        r1_black;
    logic [14:0] r1_v255;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= i_valid;
        end
        if (w_adv) begin
            r1_sat   <= n1_sat;
            r1_sec   <= n1_sec;
            r1_frac  <= n1_frac;
            r1_black <= n1_black;
            r1_v255  <= n1_v255;
        end
    end

    // stage 2: build the four weights and route them to the channels
    logic [12:0] n2_sf, n2_srf, n2_low_mul;
    logic [5:0]  n2_rfrac;
    logic [6:0]  n2_inv_sat;
    t_weight     n2_low, n2_fall, n2_rise;
    t_weight     n2_wr, n2_wg, n2_wb;

    always_comb begin
        n2_rfrac   = C_DEG_PER_SECTOR - r1_frac;
        n2_inv_sat = C_PCT_MAX - r1_sat;
        n2_sf      = {6'd0, r1_sat} * {7'd0, r1_frac};
        n2_srf     = {6'd0, r1_sat} * {7'd0, n2_rfrac};
        n2_low_mul = {6'd0, n2_inv_sat} * {7'd0, C_DEG_PER_SECTOR};
        n2_low     = n2_low_mul;
        n2_fall    = C_WEIGHT_FULL - n2_sf;
        n2_rise    = C_WEIGHT_FULL - n2_srf;
        case (r1_sec)
            SEC_R_TO_Y: begin
                n2_wr = C_WEIGHT_FULL; n2_wg = n2_rise;       n2_wb = n2_low;
            end
            SEC_Y_TO_G: begin
                n2_wr = n2_fall;       n2_wg = C_WEIGHT_FULL; n2_wb = n2_low;
            end
            SEC_G_TO_C: begin
                n2_wr = n2_low;        n2_wg = C_WEIGHT_FULL; n2_wb = n2_rise;
            end
            SEC_C_TO_B: begin
                n2_wr = n2_low;        n2_wg = n2_fall;       n2_wb = C_WEIGHT_FULL;
            end
            SEC_B_TO_M: begin
                n2_wr = n2_rise;       n2_wg = n2_low;        n2_wb = C_WEIGHT_FULL;
            end
            default: begin
                n2_wr = C_WEIGHT_FULL; n2_wg = n2_low;        n2_wb = n2_fall;
            end
        endcase
        // out-of-range hue with color gives black
        if (r1_black) begin
            n2_wr = '0;
            n2_wg = '0;
            n2_wb = '0;
        end
    end

    logic        r2_valid;
    t_weight     r2_wr, r2_wg, r2_wb;
    logic [14:0] r2_v255;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r2_valid <= r1_valid;
        end
        if (w_adv) begin
            r2_wr   <= n2_wr;
            r2_wg   <= n2_wg;
            r2_wb   <= n2_wb;
            r2_v255 <= r1_v255;
        end
    end

    // stage 3: scaled value times channel weight
    logic [C_PROD_W-1:0] n3_pr, n3_pg, n3_pb;

    always_comb begin
        n3_pr = {13'd0, r2_v255} * {15'd0, r2_wr};
        n3_pg = {13'd0, r2_v255} * {15'd0, r2_wg};
        n3_pb = {13'd0, r2_v255} * {15'd0, r2_wb};
    end

    logic                r3_valid;
    logic [C_PROD_W-1:0] r3_pr, r3_pg, r3_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r3_valid <= r2_valid;
        end
        if (w_adv) begin
            r3_pr <= n3_pr;
            r3_pg <= n3_pg;
            r3_pb <= n3_pb;
        end
    end

    // stage 4: divide by 600000 through the reciprocal, into the output register
    logic [2*C_PROD_W-1:0] n4_qr, n4_qg, n4_qb;

    always_comb begin
        n4_qr = {28'd0, r3_pr} * {28'd0, C_RECIP};
        n4_qg = {28'd0, r3_pg} * {28'd0, C_RECIP};
        n4_qb = {28'd0, r3_pb} * {28'd0, C_RECIP};
    end

    logic       r4_valid;
    logic [7:0] r4_red, r4_green, r4_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_adv) begin
            r4_valid <= r3_valid;
        end
        if (w_adv) begin
            r4_red   <= n4_qr[C_RECIP_SHIFT +: 8];
            r4_green <= n4_qg[C_RECIP_SHIFT +: 8];
            r4_blue  <= n4_qb[C_RECIP_SHIFT +: 8];
        end
    end

    assign o_valid = r4_valid;
    assign o_red   = r4_red;
    assign o_green = r4_green;
    assign o_blue  = r4_blue;

endmodule

FILE: verif/tb_hsv_to_rgb_converter.sv
// testbench for the hsv to rgb converter: random and directed colors checked against a predictor
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter
    import h2r_pkg::*;
();

    localparam int unsigned CHAN_MAX   = 255;
    localparam int          N_RANDOM   = 950;
    localparam int          GAP_MAX    = 18;
    localparam int          TAIL_CYC   = 20;
    localparam int          RUN_LIMIT  = 4_000_000;

    // one color waiting to be sent, with the idle time that follows it
    typedef struct {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] val;
        int         gap;
        bit         wait_empty;
    } t_hsv_item;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [8:0] i_hue_degrees = '0;
    logic [6:0] i_saturation_pct = '0;
    logic [6:0] i_value_pct = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;

    t_hsv_item  hsv_q[$];
    t_rgb       rgb_q[$];
    int         n_sent = 0;
    int         n_recv = 0;
    int         n_errors = 0;
    int         drv_wait = 0;
    int         rcv_wait = 0;
    bit         rcv_burst = 1'b0;

    // first degree of each sector, for the directed edge cases
    int sector_base_list[6] = '{0, 60, 120, 180, 240, 300};

    hsv_to_rgb_converter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_hue_degrees    (i_hue_degrees),
        .i_saturation_pct (i_saturation_pct),
        .i_value_pct      (i_value_pct),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hsv to rgb with exact integer rationals, percent clipped to 100
    function automatic t_rgb hsv_color(input logic [8:0] hue, input logic [6:0] sat,
                                       input logic [6:0] val);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned f;
        int unsigned full;
        int unsigned low;
        int unsigned fall;
        int unsigned rise;
        int unsigned span;
        t_sector     sec;
        t_rgb        c;
        h    = hue;
        s    = (sat > C_PCT_MAX) ? C_PCT_MAX : sat;
        v    = (val > C_PCT_MAX) ? C_PCT_MAX : val;
        span = C_PCT_MAX * C_DEG_PER_SECTOR;
        full = CHAN_MAX * v / C_PCT_MAX;
        c    = '{8'd0, 8'd0, 8'd0};
        if (s == 0) begin
            c = '{full[7:0], full[7:0], full[7:0]};
        end else if (h < C_HUE_LIMIT) begin
            sec  = t_sector'(h / C_DEG_PER_SECTOR);
            f    = h % C_DEG_PER_SECTOR;
            low  = CHAN_MAX * v * (C_PCT_MAX - s) / (C_PCT_MAX * C_PCT_MAX);
            fall = CHAN_MAX * v * (span - s * f) / (span * C_PCT_MAX);
            rise = CHAN_MAX * v * (span - s * (C_DEG_PER_SECTOR - f)) / (span * C_PCT_MAX);
            case (sec)
                SEC_R_TO_Y: c = '{full[7:0], rise[7:0], low[7:0]};
                SEC_Y_TO_G: c = '{fall[7:0], full[7:0], low[7:0]};
                SEC_G_TO_C: c = '{low[7:0], full[7:0], rise[7:0]};
                SEC_C_TO_B: c = '{low[7:0], fall[7:0], full[7:0]};
                SEC_B_TO_M: c = '{rise[7:0], low[7:0], full[7:0]};
                default:    c = '{full[7:0], low[7:0], fall[7:0]};
            endcase
        end
        return c;
    endfunction

    task automatic add_color(input int hue, input int sat, input int val, input int gap,
                             input bit wait_empty);
        t_hsv_item it;
        it.hue        = hue[8:0];
        it.sat        = sat[6:0];
        it.val        = val[6:0];
        it.gap        = gap;
        it.wait_empty = wait_empty;
        hsv_q = {hsv_q, it};
    endtask

    // sender: presents queued colors, records each transfer as an expected rgb
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            drv_wait <= 0;
        end else begin
            // transfer completing at this edge
            if (i_valid && !o_stall) begin
                rgb_q = {rgb_q, hsv_color(i_hue_degrees, i_saturation_pct, i_value_pct)};
                n_sent <= n_sent + 1;
            end
            // next color once the current one has gone
            if (!i_valid || !o_stall) begin
                if (drv_wait > 0) begin
                    i_valid  <= 1'b0;
                    drv_wait <= drv_wait - 1;
                end else if (hsv_q.size() > 0 &&
                             (!hsv_q[0].wait_empty || (!i_valid && n_sent == n_recv))) begin
                    i_valid          <= 1'b1;
                    i_hue_degrees    <= hsv_q[0].hue;
                    i_saturation_pct <= hsv_q[0].sat;
                    i_value_pct      <= hsv_q[0].val;
                    drv_wait         <= hsv_q[0].gap;
                    void'(hsv_q.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each rgb transfer and stalls at random afterwards
    always @(posedge i_clk) begin
        t_rgb want;
        int   w;
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            rcv_wait <= 0;
        end else if (o_valid && !i_stall) begin
            if (n_recv >= n_sent) begin
                $error("unexpected rgb transfer: red %0d green %0d blue %0d",
                       o_red, o_green, o_blue);
                n_errors++;
            end else begin
                want = rgb_q.pop_front();
                if (o_red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, o_red);
                    n_errors++;
                end
                if (o_green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, o_green);
                    n_errors++;
                end
                if (o_blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, o_blue);
                    n_errors++;
                end
                n_recv <= n_recv + 1;
                if (n_recv % 40 == 0)
                    rcv_burst <= ($urandom_range(0, 2) == 0);
            end
            w = rcv_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (w > 0) begin
                i_stall  <= 1'b1;
                rcv_wait <= w;
            end
        end else if (rcv_wait > 1) begin
            rcv_wait <= rcv_wait - 1;
        end else if (rcv_wait == 1) begin
            rcv_wait <= 0;
            i_stall  <= 1'b0;
        end
    end

    // stimulus and end of run
    initial begin
        int hue;
        int sat;
        int val;
        int gap;
        int gap_mode;
        int n_directed;
        // grey, black and clipped percent cases
        add_color(0, 0, 100, 0, 1'b0);
        add_color(400, 0, 57, 0, 1'b0);
        add_color(511, 100, 100, 0, 1'b0);
        add_color(360, 1, 100, 3, 1'b0);
        add_color(30, 127, 127, 0, 1'b0);
        add_color(200, 101, 100, 1, 1'b0);
        add_color(0, 0, 0, 0, 1'b0);
        add_color(150, 100, 0, 0, 1'b0);
        // both edges of every sector
        foreach (sector_base_list[k]) begin
            add_color(sector_base_list[k], 100, 100, k % 3, 1'b0);
            add_color(sector_base_list[k] + 59, 100, 100, 0, 1'b0);
        end
        add_color(359, 50, 73, 0, 1'b0);
        add_color(1, 99, 1, 0, 1'b0);
        n_directed = hsv_q.size();

        // random colors, mostly legal, in phases of different sender pacing
        gap_mode = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 50 == 0)
                gap_mode = $urandom_range(0, 2);
            hue = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 359);
            sat = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
            val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
            if ($urandom_range(0, 19) == 0)
                sat = 0;
            case (gap_mode)
                0:       gap = 0;
                1:       gap = $urandom_range(0, GAP_MAX);
                default: gap = $urandom_range(0, 2);
            endcase
            add_color(hue, sat, val, gap, (i == 0) || (i == 400) || (i == 777));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (hsv_q.size() > 0 || i_valid);
        do @(posedge i_clk); while (n_recv != n_sent);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (rgb_q.size() != 0) begin
            $error("%0d expected rgb results never arrived", rgb_q.size());
            n_errors++;
        end

        $display("summary: %0d colors converted (%0d directed: grey, black, clipped, sector edges)",
                 n_recv, n_directed);
        $display("summary: random colors under random sender gaps and receiver stalls, %0d errors",
                 n_errors);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
